// File: src/h2r_pkg.sv
// Shared constants, region codes and stage-load struct for the HSL to RGBA converter.
// No dependencies; imported by h2r_channel and hsl_to_rgba_converter.
package h2r_pkg;

  localparam int FRAC_BITS_DEF = 16;   // Q1.16 saturation, lightness and alpha
  localparam int NSTG          = 7;    // pipeline stages, last one is the output register

  localparam int HUE_W = 16;
  localparam int FLD_W = 17;           // saturation, lightness, alpha field width
  localparam int POS_W = 19;           // ramp position, 6*t in units of 1/65536
  localparam int M_W   = 20;           // signed M1 / M2 levels
  localparam int DD_W  = 20;           // non-negative M2 - M1
  localparam int X_W   = 17;           // ramp distance, at most 65536

  // hue offsets in units of 1/(3*65536) turn
  localparam logic [POS_W-1:0] HUE_THIRD  = 19'd65536;
  localparam logic [POS_W-1:0] HUE_2THIRD = 19'd131072;
  localparam logic [POS_W-1:0] HUE3_TURN  = 19'd196608;

  // region bounds on the ramp position: 1/6, 1/2 and 2/3 turn
  localparam logic [POS_W-1:0] POS_SIXTH = 19'd65536;
  localparam logic [POS_W-1:0] POS_HALF  = 19'd196608;
  localparam logic [POS_W-1:0] POS_TWO3  = 19'd262144;

  typedef enum logic [1:0] {
    RGN_RISE,
    RGN_HIGH,
    RGN_FALL,
    RGN_LOW
  } h2r_rgn_t;

  // load enables for the per-channel stages
  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } h2r_ld_t;

endpackage

// File: src/h2r_channel.sv
// One color channel: hue ramp region, ramp multiply, clamp and scale to a byte.
// Stages 4 to 7 of the converter pipeline; depends on h2r_pkg.
module h2r_channel import h2r_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  h2r_ld_t                ld,
  input  logic [POS_W-1:0]       pos,
  input  logic signed [M_W-1:0]  m1,
  input  logic signed [M_W-1:0]  m2,
  input  logic [DD_W-1:0]        dd,
  output logic [7:0]             chan
);

  localparam int LVL_W  = FRAC_BITS + 1;
  localparam int VW     = (FRAC_BITS + 2 > 23) ? FRAC_BITS + 2 : 23;
  localparam int PROD_W = DD_W + X_W;
  localparam int RAMP_W = PROD_W - 16;
  localparam int SCL_W  = LVL_W + 8;
  localparam logic signed [VW-1:0] ONE_V = {{(VW-1){1'b0}}, 1'b1} << FRAC_BITS;

  // stage 4: region and ramp distance
  h2r_rgn_t              rgn_nxt, rgn_4_r, rgn_5_r;
  logic [X_W-1:0]        x_nxt, x_4_r;
  logic [POS_W-1:0]      fall_x;
  logic signed [M_W-1:0] m1_4_r, m2_4_r, m1_5_r, m2_5_r;
  logic [DD_W-1:0]       dd_4_r;

  assign fall_x = POS_TWO3 - pos;

  always_comb begin
    if (pos < POS_SIXTH) begin
      rgn_nxt = RGN_RISE;
      x_nxt   = pos[X_W-1:0];
    end else if (pos < POS_HALF) begin
      rgn_nxt = RGN_HIGH;
      x_nxt   = '0;
    end else if (pos < POS_TWO3) begin
      rgn_nxt = RGN_FALL;
      x_nxt   = fall_x[X_W-1:0];
    end else begin
      rgn_nxt = RGN_LOW;
      x_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s4) begin
      rgn_4_r <= rgn_nxt;
      x_4_r   <= x_nxt;
      m1_4_r  <= m1;
      m2_4_r  <= m2;
      dd_4_r  <= dd;
    end
  end

  // stage 5: (M2 - M1) * distance
  logic [PROD_W-1:0] prod_nxt, prod_5_r;

  assign prod_nxt = {{X_W{1'b0}}, dd_4_r} * {{DD_W{1'b0}}, x_4_r};

  always_ff @(posedge clk) begin
    if (ld.s5) begin
      prod_5_r <= prod_nxt;
      rgn_5_r  <= rgn_4_r;
      m1_5_r   <= m1_4_r;
      m2_5_r   <= m2_4_r;
    end
  end

  // stage 6: level select and clamp to [0, 1.0]
  logic [RAMP_W-1:0]    ramp;
  logic signed [VW-1:0] m1_e, m2_e, ramp_e, sum;
  logic [LVL_W-1:0]     lvl_nxt, lvl_6_r;
  logic signed [VW-1:0] lvl_c;

  assign ramp   = prod_5_r[PROD_W-1:16];
  assign m1_e   = VW'(m1_5_r);
  assign m2_e   = VW'(m2_5_r);
  assign ramp_e = $signed(VW'(ramp));

  always_comb begin
    case (rgn_5_r)
      RGN_RISE: sum = m1_e + ramp_e;
      RGN_FALL: sum = m1_e + ramp_e;
      RGN_HIGH: sum = m2_e;
      default:  sum = m1_e;
    endcase
    if (sum < 0) begin
      lvl_c = '0;
    end else if (sum > ONE_V) begin
      lvl_c = ONE_V;
    end else begin
      lvl_c = sum;
    end
    lvl_nxt = lvl_c[LVL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld.s6) begin
      lvl_6_r <= lvl_nxt;
    end
  end

  // stage 7: floor(255 * level)
  logic [SCL_W-1:0] scl, scl_sh;
  logic [7:0]       chan_nxt, chan_7_r;

  assign scl      = SCL_W'(lvl_6_r) * SCL_W'(255);
  assign scl_sh   = scl >> FRAC_BITS;
  assign chan_nxt = scl_sh[7:0];

  always_ff @(posedge clk) begin
    if (ld.s7) begin
      chan_7_r <= chan_nxt;
    end
  end

  assign chan = chan_7_r;

endmodule

// File: src/hsl_to_rgba_converter.sv
// Top level of the HSL to RGBA converter: input clamp, hue offsets, M1/M2 levels,
// three h2r_channel instances and the alpha path. Depends on h2r_pkg and h2r_channel.
//
//  channel | dir | handshake              | word
//  in      | in  | in_tvalid / in_tready   | hue, saturation, lightness, alpha_in
//  out     | out | out_tvalid / out_tready | red, green, blue, alpha_out
//
// One word per clock sustained while out_tready is high; each word passes all seven pipeline registers.
// Two multipliers deep per channel (ramp and x255) plus L*S set the stage count.
// Synchronous active-low reset clears the stage valid bits only.
// A stall on out_tready holds each full stage; empty stages still fill, so
// in_tready drops only when all seven stages hold a word.
module hsl_to_rgba_converter import h2r_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // hue[15:0], saturation[32:16], lightness[49:33],
                                  // alpha_in[66:50], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // red[7:0], green[15:8], blue[23:16], alpha_out[31:24]
);

  localparam logic [31:0] ONE32  = 32'd1 << FRAC_BITS;
  localparam logic [31:0] HALF32 = 32'd1 << (FRAC_BITS - 1);
  localparam int LSP_W = 2 * FLD_W;
  localparam int A255_W = FLD_W + 8;

  // stage valid bits and ready chain
  logic [NSTG:1]   vld_r, vld_nxt;
  logic [NSTG+1:1] rdy;
  h2r_ld_t         ld;

  always_comb begin
    rdy[NSTG+1] = out_tready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[1] = rdy[1] ? in_tvalid : vld_r[1];
    for (int k = 2; k <= NSTG; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ld        = '{s4: rdy[4], s5: rdy[5], s6: rdy[6], s7: rdy[7]};
  assign in_tready = rdy[1];

  // stage 1: clamp, hue scaled by 3 and its third-turn offsets
  logic [HUE_W-1:0] hue;
  logic [FLD_W-1:0] sat, lit, alp;
  logic [FLD_W-1:0] s_nxt, l_nxt, a_nxt, s_1_r, l_1_r, a_1_r;
  logic [17:0]      h3;
  logic [POS_W-1:0] hr_t, hb_t, hr, hb;
  logic [POS_W-1:0] posr_nxt, posg_nxt, posb_nxt;
  logic [POS_W-1:0] posr_1_r, posg_1_r, posb_1_r;

  assign hue = in_tdata[15:0];
  assign sat = in_tdata[32:16];
  assign lit = in_tdata[49:33];
  assign alp = in_tdata[66:50];

  assign s_nxt = ({15'd0, sat} > ONE32) ? ONE32[FLD_W-1:0] : sat;
  assign l_nxt = ({15'd0, lit} > ONE32) ? ONE32[FLD_W-1:0] : lit;
  assign a_nxt = ({15'd0, alp} > ONE32) ? ONE32[FLD_W-1:0] : alp;

  assign h3   = {2'b00, hue} + {1'b0, hue, 1'b0};
  assign hr_t = {1'b0, h3} + HUE_THIRD;
  assign hb_t = {1'b0, h3} + HUE_2THIRD;
  assign hr   = (hr_t >= HUE3_TURN) ? hr_t - HUE3_TURN : hr_t;
  assign hb   = (hb_t >= HUE3_TURN) ? hb_t - HUE3_TURN : hb_t;

  assign posr_nxt = {hr[17:0], 1'b0};
  assign posg_nxt = {h3, 1'b0};
  assign posb_nxt = {hb[17:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s_1_r    <= s_nxt;
      l_1_r    <= l_nxt;
      a_1_r    <= a_nxt;
      posr_1_r <= posr_nxt;
      posg_1_r <= posg_nxt;
      posb_1_r <= posb_nxt;
    end
  end

  // stage 2: L*S and 255*alpha
  logic [LSP_W-1:0]  lsp_nxt, lsp_2_r;
  logic [A255_W-1:0] a255_nxt, a255_2_r;
  logic [FLD_W-1:0]  s_2_r, l_2_r;
  logic [POS_W-1:0]  posr_2_r, posg_2_r, posb_2_r;

  assign lsp_nxt  = {{FLD_W{1'b0}}, l_1_r} * {{FLD_W{1'b0}}, s_1_r};
  assign a255_nxt = {a_1_r, 8'd0} - {8'd0, a_1_r};

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      lsp_2_r  <= lsp_nxt;
      a255_2_r <= a255_nxt;
      s_2_r    <= s_1_r;
      l_2_r    <= l_1_r;
      posr_2_r <= posr_1_r;
      posg_2_r <= posg_1_r;
      posb_2_r <= posb_1_r;
    end
  end

  // stage 3: M2, M1, non-negative M2 - M1, alpha byte
  logic [LSP_W-1:0]      lsp_sh;
  logic [17:0]           ls;
  logic [M_W-1:0]        m2u;
  logic signed [M_W-1:0] m2_nxt, m1_nxt, m1_3_r, m2_3_r;
  logic signed [M_W:0]   d;
  logic [DD_W-1:0]       dd_nxt, dd_3_r;
  logic [A255_W-1:0]     a255_sh;
  logic [7:0]            alpha_nxt, alpha_3_r, alpha_4_r, alpha_5_r, alpha_6_r, alpha_7_r;
  logic [POS_W-1:0]      posr_3_r, posg_3_r, posb_3_r;

  assign lsp_sh = lsp_2_r >> FRAC_BITS;
  assign ls     = lsp_sh[17:0];

  always_comb begin
    if ({15'd0, l_2_r} <= HALF32) begin
      m2u = M_W'(l_2_r) + M_W'(ls);
    end else begin
      m2u = M_W'(l_2_r) + M_W'(s_2_r) - M_W'(ls);
    end
  end

  assign m2_nxt    = $signed(m2u);
  assign m1_nxt    = $signed(M_W'({l_2_r, 1'b0})) - m2_nxt;
  assign d         = (M_W+1)'(m2_nxt) - (M_W+1)'(m1_nxt);
  assign dd_nxt    = d[M_W] ? '0 : d[DD_W-1:0];
  assign a255_sh   = a255_2_r >> FRAC_BITS;
  assign alpha_nxt = a255_sh[7:0];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      m1_3_r    <= m1_nxt;
      m2_3_r    <= m2_nxt;
      dd_3_r    <= dd_nxt;
      alpha_3_r <= alpha_nxt;
      posr_3_r  <= posr_2_r;
      posg_3_r  <= posg_2_r;
      posb_3_r  <= posb_2_r;
    end
  end

  // stages 4 to 7: channels, alpha delayed alongside
  logic [7:0] red, green, blue;

  h2r_channel #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk(clk), .ld(ld), .pos(posr_3_r), .m1(m1_3_r), .m2(m2_3_r), .dd(dd_3_r), .chan(red)
  );

  h2r_channel #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk(clk), .ld(ld), .pos(posg_3_r), .m1(m1_3_r), .m2(m2_3_r), .dd(dd_3_r), .chan(green)
  );

  h2r_channel #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk(clk), .ld(ld), .pos(posb_3_r), .m1(m1_3_r), .m2(m2_3_r), .dd(dd_3_r), .chan(blue)
  );

  always_ff @(posedge clk) begin
    if (ld.s4) begin
      alpha_4_r <= alpha_3_r;
    end
    if (ld.s5) begin
      alpha_5_r <= alpha_4_r;
    end
    if (ld.s6) begin
      alpha_6_r <= alpha_5_r;
    end
    if (ld.s7) begin
      alpha_7_r <= alpha_6_r;
    end
  end

  assign out_tvalid = vld_r[NSTG];
  assign out_tdata  = {alpha_7_r, blue, green, red};

  // checks
  logic in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // words in flight change only by accepted input and delivered output
  a_count: assert property (@(posedge clk)
    rst_n && $past(rst_n) |->
      ($countones(vld_r) == $past($countones(vld_r)) + $past(in_acc) - $past(out_acc)))
    else $error("pipeline word count mismatch");

  // input back-pressure only with every stage full
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&vld_r))
    else $error("in_tready low with a free stage");

  // output word always comes from the stage before it
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vld_r[NSTG]) |-> $past(vld_r[NSTG-1]))
    else $error("output valid without a word in stage 6");

endmodule
